// ===== design/sitoda_pkg.sv =====
package sitoda_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;

    localparam int CHAR_BITS = 6;
    localparam int DIGIT_BITS = 4;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

// ===== design/sitoda_dabble_step.sv =====
module sitoda_dabble_step #(
    parameter int VALUE_BITS = sitoda_pkg::DEFAULT_VALUE_BITS,
    parameter int DIGITS     = 10
) (
    input  logic [sitoda_pkg::DIGIT_BITS*DIGITS-1:0] bcd_i,
    input  logic [VALUE_BITS-1:0]                    mag_i,
    output logic [sitoda_pkg::DIGIT_BITS*DIGITS-1:0] bcd_o,
    output logic [VALUE_BITS-1:0]                    mag_o
);
    import sitoda_pkg::*;

    localparam int BCD_BITS = DIGIT_BITS * DIGITS;

    logic [BCD_BITS-1:0] adj;

    // Add 3 to every digit of 5 or more, then shift one magnitude bit in
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_i[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_i[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end else begin
                adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_i[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    assign bcd_o = {adj[BCD_BITS-2:0], mag_i[VALUE_BITS-1]};
    assign mag_o = {mag_i[VALUE_BITS-2:0], 1'b0};

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter.
// Slave channel: one word per integer; s_tdata carries value (VALUE_BITS wide,
// two's complement), zero-padded to whole bytes. Bits above the field are ignored.
// Master channel: one word per character, most significant first. m_tdata carries
// character ('-' or '0'..'9', 6 bits) padded to 8 bits; m_tlast marks the last
// character of the number. Negative values start with '-'; leading zeros are
// dropped and zero gives a single '0'. The most negative value converts exactly.
// Timing: one value at a time. After acceptance the shared shift-add-3 unit runs
// one magnitude bit per cycle, then leading zero digits are dropped one per cycle,
// then one character per cycle leaves through the output register while the
// receiver is ready; s_tready is high only while the sequencer is idle.
// If the receiver stalls, the output register holds its word and the sequencer
// waits; nothing is lost. Reset (aresetn low, synchronous) drops any value in
// flight and any pending output word and returns to idle.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitoda_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,  // [VALUE_BITS-1:0] value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,  // [5:0] character
    output logic                                 m_tlast   // last
);
    import sitoda_pkg::*;

    // Decimal digits enough for 2^(VALUE_BITS-1); log10(2) ~ 0.30103
    localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS = DIGIT_BITS * DIGITS;
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam int DL_BITS  = $clog2(DIGITS + 1);

    localparam logic [CNT_BITS-1:0] LAST_BIT   = CNT_BITS'(VALUE_BITS - 1);
    localparam logic [DL_BITS-1:0]  ALL_DIGITS = DL_BITS'(DIGITS);
    localparam logic [DL_BITS-1:0]  ONE_DIGIT  = DL_BITS'(1);

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [DL_BITS-1:0]    left_reg, left_next;
    logic                  minus_reg, minus_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]  out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [BCD_BITS-1:0]   step_bcd;
    logic [VALUE_BITS-1:0] step_mag;
    logic [VALUE_BITS-1:0] in_value;
    logic [DIGIT_BITS-1:0] top_digit;
    logic                  slot_free;

    sitoda_dabble_step #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_step (
        .bcd_i (bcd_reg),
        .mag_i (mag_reg),
        .bcd_o (step_bcd),
        .mag_o (step_mag)
    );

    assign in_value  = s_tdata[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_BITS-1 -: DIGIT_BITS];
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        minus_next     = minus_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // Magnitude fits in VALUE_BITS unsigned, even for the most negative
                    minus_next = in_value[VALUE_BITS-1];
                    mag_next   = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                // Advance one magnitude bit through the shift-add-3 unit
                bcd_next = step_bcd;
                mag_next = step_mag;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT) begin
                    left_next  = ALL_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, keep at least one digit
                if (top_digit == '0 && left_reg != ONE_DIGIT) begin
                    bcd_next  = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    left_next = left_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    if (minus_reg) begin
                        out_char_next = ASCII_MINUS;
                        out_last_next = 1'b0;
                        minus_next    = 1'b0;
                    end else begin
                        out_char_next = ASCII_ZERO + CHAR_BITS'(top_digit);
                        out_last_next = (left_reg == ONE_DIGIT);
                        bcd_next  = {bcd_reg[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                        left_next = left_reg - 1'b1;
                        if (left_reg == ONE_DIGIT) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            minus_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            minus_reg     <= minus_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        left_reg     <= left_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

    import sitoda_pkg::*;

    localparam int VALUE_BITS    = 32;
    localparam int DATA_BITS     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_ITEMS  = 410;
    localparam int QUIET_ITEMS   = 50;   // final random words sent with no idling
    localparam int DRAIN_CYCLES  = 60;   // more than one full conversion

    // One expected output word: the character and its end-of-number flag.
    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } ascii_char_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata;   // [31:0] value
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [5:0] character, [7:6] zero padding
    logic                 m_tlast;   // last

    ascii_char_t pending_chars[$];
    int          mismatch_count = 0;
    bit          quiet_tail     = 1'b0;

    // Directed table. An empty text means: take the expectation from the predictor.
    logic [31:0] directed_value [0:DIRECTED_ROWS-1] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'd1000000000, -32'sd1000000000, 32'd999999999,
        32'd99, 32'd100, -32'sd12345, 32'd123456789, -32'sd987654321,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_0000, 32'd1999999999,
        -32'sd2000000000, 32'h0000_FFFF
    };
    string directed_text [0:DIRECTED_ROWS-1] = '{
        "0", "1", "-1", "9", "10", "-10",
        "2147483647", "-2147483648", "-2147483647",
        "1000000000", "-1000000000", "999999999",
        "", "", "", "", "", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Build the decimal text of one value: sign first, then digits, most
    // significant first, leading zeros dropped. The magnitude is kept one bit
    // wider so the most negative value converts exactly.
    function automatic void predict_decimal_text(input logic [31:0] value);
        logic [32:0]          magnitude;
        logic [CHAR_BITS-1:0] text_chars[$];
        ascii_char_t          entry;
        magnitude = value[31] ? (~{1'b1, value} + 33'd1) : {1'b0, value};
        do begin
            text_chars.push_front(ASCII_ZERO + CHAR_BITS'(magnitude % 33'd10));
            magnitude = magnitude / 33'd10;
        end while (magnitude != 33'd0);
        if (value[31]) begin
            text_chars.push_front(ASCII_MINUS);
        end
        foreach (text_chars[i]) begin
            entry.character = text_chars[i];
            entry.last      = (i == text_chars.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    // Queue a typed-in expected string as output words.
    function automatic void queue_typed_text(input string text);
        ascii_char_t entry;
        for (int i = 0; i < text.len(); i++) begin
            entry.character = CHAR_BITS'(text[i]);
            entry.last      = (i == text.len() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    // Random values, weighted toward digit-count boundaries and extremes.
    function automatic logic [31:0] random_value();
        longint  magnitude;
        longint  low_bound;
        longint  high_bound;
        longint  power;
        int      digits;
        bit      negate;
        negate = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return $urandom;
            end
            4, 5: begin
                // Uniform over one digit count, so short numbers get their share.
                digits = $urandom_range(1, 10);
                power = 1;
                repeat (digits - 1) power *= 10;
                low_bound  = (digits == 1) ? 0 : power;
                high_bound = power * 10 - 1;
                if (high_bound > 64'd2147483647) begin
                    high_bound = 64'd2147483647;
                end
                magnitude = low_bound + $urandom_range(0, int'(high_bound - low_bound));
            end
            6: begin
                // Powers of ten, one below and one above.
                power = 1;
                repeat ($urandom_range(0, 9)) power *= 10;
                magnitude = power + $urandom_range(0, 2) - 1;
            end
            7: begin
                magnitude = $urandom_range(0, 20);
            end
            8: begin
                // Hug the signed extremes.
                if (negate) begin
                    return 32'h8000_0000 + $urandom_range(0, 15);
                end
                return 32'h7FFF_FFFF - $urandom_range(0, 15);
            end
            default: begin
                // Walking one or walking zero.
                magnitude = 64'd1 << $urandom_range(0, 31);
                return negate ? ~magnitude[31:0] : magnitude[31:0];
            end
        endcase
        return negate ? 32'(-magnitude) : 32'(magnitude);
    endfunction

    // Drop s_tvalid for a random burst, scrambling s_tdata meanwhile.
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 17)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
            end
        end
    endtask

    // Offer one word and hold it until accepted; then queue what it should produce.
    task automatic offer_value(input logic [31:0] value, input string text);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (text.len() == 0) begin
            predict_decimal_text(value);
        end else begin
            queue_typed_text(text);
        end
    endtask

    // Stimulus: reset, directed table, random values, then drain.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            sender_gap();
            offer_value(directed_value[row], directed_text[row]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet_tail = 1'b1;
            end
            sender_gap();
            offer_value(random_value(), "");
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Wait out every expected word, then watch a while for strays.
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: alternate ready runs with stall bursts; stop stalling at the tail.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 17)) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Check each accepted output word against the oldest expectation.
    always @(posedge aclk) begin
        ascii_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("character: expected none, got %0d (last %0d)",
                       m_tdata[CHAR_BITS-1:0], m_tlast);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_BITS-1:0] !== want.character) begin
                    $error("character: expected %0d, got %0d",
                           want.character, m_tdata[CHAR_BITS-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[7:CHAR_BITS] !== '0) begin
                    $error("m_tdata padding: expected 0, got %0d", m_tdata[7:CHAR_BITS]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #1_500_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
design/sitoda_pkg.sv
design/sitoda_dabble_step.sv
design/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
